/* design/rotation_matrix_to_euler_xyz_unit_macros.svh */
// Assertion helpers shared by the checker
`ifndef ROTATION_MATRIX_TO_EULER_XYZ_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_XYZ_UNIT_MACROS_SVH

// Checked only outside reset
`define RM2EUL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define RM2EUL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/rm2eul_pkg.sv */
package rm2eul_pkg;

  localparam int DEF_CORDIC_STEPS = 16;
  localparam int DEF_DATA_WIDTH   = 16;

  localparam int IN_W      = 16;
  localparam int CFG_W     = 15;
  localparam int ROOT_W    = 15;
  localparam int RAD_W     = 29;   // 2^28 - s^2 fits in 29 bits
  localparam int SQ_W      = 30;
  localparam int SQ_STAGES = 15;
  localparam int ACC_W     = 34;   // radians * 2^30 with headroom
  localparam int RND_SH    = 17;
  localparam int RES_W     = ACC_W - RND_SH;
  localparam int TAB_LEN   = 24;

  localparam logic signed [IN_W-1:0]  ONE_Q14     = 16'sd16384;
  localparam logic signed [RES_W-1:0] PI_Q13      = 17'sd25736;
  localparam logic signed [RES_W-1:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [RAD_W-1:0]        ONE_SQ      = 29'd268435456;

  typedef struct packed {
    logic signed [IN_W-1:0] m00;
    logic signed [IN_W-1:0] m01;
    logic signed [IN_W-1:0] m10;
    logic signed [IN_W-1:0] m11;
    logic signed [IN_W-1:0] m12;
    logic signed [IN_W-1:0] m22;
  } mat_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [ACC_W-1:0] atan_tab(input int i);
    logic signed [ACC_W-1:0] r;
    unique case (i)
      0:  r = 34'sh03243F6A8;
      1:  r = 34'sh01DAC6705;
      2:  r = 34'sh00FADBAFC;
      3:  r = 34'sh007F56EA6;
      4:  r = 34'sh003FEAB76;
      5:  r = 34'sh001FFD55B;
      6:  r = 34'sh000FFFAAA;
      7:  r = 34'sh0007FFF55;
      8:  r = 34'sh0003FFFEA;
      9:  r = 34'sh0001FFFFD;
      10: r = 34'sh0000FFFFF;
      11: r = 34'sh00007FFFF;
      12: r = 34'sh00003FFFF;
      13: r = 34'sh00001FFFF;
      14: r = 34'sh00000FFFF;
      15: r = 34'sh000007FFF;
      16: r = 34'sh000003FFF;
      17: r = 34'sh000001FFF;
      18: r = 34'sh000000FFF;
      19: r = 34'sh0000007FF;
      20: r = 34'sh0000003FF;
      21: r = 34'sh0000001FF;
      22: r = 34'sh0000000FF;
      23: r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // symmetric saturation
  function automatic logic signed [RES_W-1:0] sat(input logic signed [RES_W-1:0] v,
                                                 input logic signed [RES_W-1:0] lim);
    logic signed [RES_W-1:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

endpackage

/* design/rm2eul_isqrt.sv */
module rm2eul_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rm2eul_pkg::RAD_W-1:0]  rad,
  output logic [rm2eul_pkg::ROOT_W-1:0] root
);
  import rm2eul_pkg::*;

  logic [SQ_W-1:0] rem [0:SQ_STAGES];
  logic [SQ_W-1:0] res [0:SQ_STAGES];

  assign rem[0] = SQ_W'(rad);
  assign res[0] = '0;

  // one result bit per stage, trial bit 2^(28-2k)
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    localparam logic [SQ_W-1:0] TBIT = SQ_W'(1) << (2 * (SQ_STAGES - 1 - k));
    logic [SQ_W-1:0] trial;
    assign trial = res[k] + TBIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + TBIT;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign root = res[SQ_STAGES][ROOT_W-1:0];
endmodule

/* design/rm2eul_cordic.sv */
module rm2eul_cordic #(
  parameter int STEPS      = rm2eul_pkg::DEF_CORDIC_STEPS,
  parameter int DATA_WIDTH = rm2eul_pkg::DEF_DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [rm2eul_pkg::IN_W-1:0]  y_in,
  input  logic signed [rm2eul_pkg::IN_W-1:0]  x_in,
  output logic signed [rm2eul_pkg::RES_W-1:0] angle
);
  import rm2eul_pkg::*;

  localparam int SH = DATA_WIDTH - 6;
  localparam int XW = IN_W + SH + 3;
  localparam int NS = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;

  logic signed [XW-1:0]    xv  [0:NS];
  logic signed [XW-1:0]    yv  [0:NS];
  logic signed [ACC_W-1:0] acc [0:NS];
  logic                    zf  [0:NS];

  logic signed [XW-1:0]    xe, ye, x0, y0;
  logic signed [ACC_W-1:0] a0;

  // scale and fold into the right half plane
  always_comb begin
    xe = XW'(x_in) <<< SH;
    ye = XW'(y_in) <<< SH;
    x0 = xe;
    y0 = ye;
    a0 = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        a0 = HALF_PI_Q30;
      end else begin
        x0 = -ye;
        y0 = xe;
        a0 = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xv[0]  <= x0;
      yv[0]  <= y0;
      acc[0] <= a0;
      zf[0]  <= (x_in == 0) && (y_in == 0);
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < NS; i++) begin : g_iter
    localparam logic signed [ACC_W-1:0] TAB = atan_tab(i);
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (yv[i] >= 0) begin
          xv[i+1]  <= xv[i] + (yv[i] >>> i);
          yv[i+1]  <= yv[i] - (xv[i] >>> i);
          acc[i+1] <= acc[i] + TAB;
        end else begin
          xv[i+1]  <= xv[i] - (yv[i] >>> i);
          yv[i+1]  <= yv[i] + (xv[i] >>> i);
          acc[i+1] <= acc[i] - TAB;
        end
      end
    end
  end

  // round to Q3.13
  logic signed [ACC_W-1:0] rnd;
  assign rnd = acc[NS] + (ACC_W'(1) <<< (RND_SH - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zf[NS] ? '0 : rnd[ACC_W-1:RND_SH];
    end
  end
endmodule

/* design/rotation_matrix_to_euler_xyz_unit.sv */
// Pipeline: input/square register, square-root stages, CORDIC pre-rotation and
// micro-rotation steps (capped at 24 steps), rounding, output register.
// Throughput: one matrix per cycle; the whole pipeline advances whenever the
// output register is empty or being taken.
// Reset: synchronous rst clears all valid bits and lock_threshold to 0.
module rotation_matrix_to_euler_xyz_unit #(
  parameter int CORDIC_STEPS = rm2eul_pkg::DEF_CORDIC_STEPS,
  parameter int DATA_WIDTH   = rm2eul_pkg::DEF_DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rm2eul_pkg::CFG_W-1:0]     cfg_wdata,     // lock_threshold
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [111:0]                     s_axis_tdata,  // m00,m01,m02,m10,m11,m12,m22
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [47:0]                      m_axis_tdata,  // roll_x,pitch_y,yaw_z,pad
  output logic                             m_axis_tuser   // gimbal_lock
);
  import rm2eul_pkg::*;

  localparam int NS    = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int CD    = NS + 2;
  localparam int LAT   = 1 + SQ_STAGES + CD + 1;

  logic en;
  logic [CFG_W-1:0] lock_threshold;
  logic [LAT-1:0]   vld;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_threshold <= '0;
    end else if (cfg_we) begin
      lock_threshold <= cfg_wdata;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // input stage: saturate m02 and form 1 - s^2
  logic signed [IN_W-1:0] m02_in, s_sat;
  logic [RAD_W-1:0]       rad_a;
  logic [SQ_W-1:0]        s_sq;
  mat_t                   mat_in;
  mat_t                   mat_d [0:SQ_STAGES];
  logic signed [IN_W-1:0] s_d   [0:SQ_STAGES];

  assign m02_in = s_axis_tdata[47:32];
  assign s_sat  = (m02_in > ONE_Q14) ? ONE_Q14 : ((m02_in < -ONE_Q14) ? -ONE_Q14 : m02_in);
  assign s_sq   = SQ_W'(s_sat * s_sat);
  assign mat_in = '{m00: s_axis_tdata[15:0],   m01: s_axis_tdata[31:16],
                    m10: s_axis_tdata[63:48],  m11: s_axis_tdata[79:64],
                    m12: s_axis_tdata[95:80],  m22: s_axis_tdata[111:96]};

  // input registers, operands carried alongside the root pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      rad_a    <= RAD_W'(SQ_W'(ONE_SQ) - s_sq);
      mat_d[0] <= mat_in;
      s_d[0]   <= s_sat;
      for (int k = 1; k <= SQ_STAGES; k++) begin
        mat_d[k] <= mat_d[k-1];
        s_d[k]   <= s_d[k-1];
      end
    end
  end

  logic [ROOT_W-1:0] c_root;

  rm2eul_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad_a),
    .root (c_root)
  );

  // four arctangents side by side; lock picks at the end
  mat_t                   mq;
  logic signed [IN_W-1:0] c_sgn;
  logic signed [RES_W-1:0] ang_p, ang_r, ang_ya, ang_yb;

  assign mq    = mat_d[SQ_STAGES];
  assign c_sgn = IN_W'(c_root);

  rm2eul_cordic #(.STEPS(CORDIC_STEPS), .DATA_WIDTH(DATA_WIDTH)) u_pitch (
    .clk(clk), .en(en), .y_in(s_d[SQ_STAGES]), .x_in(c_sgn), .angle(ang_p));
  rm2eul_cordic #(.STEPS(CORDIC_STEPS), .DATA_WIDTH(DATA_WIDTH)) u_roll (
    .clk(clk), .en(en), .y_in(mq.m12), .x_in(mq.m22), .angle(ang_r));
  rm2eul_cordic #(.STEPS(CORDIC_STEPS), .DATA_WIDTH(DATA_WIDTH)) u_yaw (
    .clk(clk), .en(en), .y_in(mq.m01), .x_in(mq.m00), .angle(ang_ya));
  rm2eul_cordic #(.STEPS(CORDIC_STEPS), .DATA_WIDTH(DATA_WIDTH)) u_yaw_lock (
    .clk(clk), .en(en), .y_in(mq.m10), .x_in(mq.m11), .angle(ang_yb));

  // lock decision travels with the CORDIC stages
  logic lock_d [0:CD-1];

  always_ff @(posedge clk) begin
    if (en) begin
      lock_d[0] <= !(c_root > lock_threshold);
      for (int k = 1; k < CD; k++) begin
        lock_d[k] <= lock_d[k-1];
      end
    end
  end

  // output register
  logic signed [RES_W-1:0] pitch_s, roll_s, yaw_s;
  logic signed [IN_W-1:0]  roll_x, yaw_z;
  logic signed [14:0]      pitch_y;
  logic                    gimbal_lock;

  assign pitch_s = sat(ang_p, HALF_PI_Q13);
  assign roll_s  = lock_d[CD-1] ? '0 : sat(ang_r, PI_Q13);
  assign yaw_s   = sat(lock_d[CD-1] ? ang_yb : ang_ya, PI_Q13);

  always_ff @(posedge clk) begin
    if (en) begin
      roll_x      <= roll_s[IN_W-1:0];
      pitch_y     <= pitch_s[14:0];
      yaw_z       <= yaw_s[IN_W-1:0];
      gimbal_lock <= lock_d[CD-1];
    end
  end

  assign m_axis_tdata = {1'b0, yaw_z, pitch_y, roll_x};
  assign m_axis_tuser = gimbal_lock;
endmodule

/* design/rm2eul_checker.sv */
`include "rotation_matrix_to_euler_xyz_unit_macros.svh"

module rm2eul_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  logic signed [14:0] pitch;
  assign pitch = m_axis_tdata[30:16];

  // result held until taken
  `RM2EUL_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
  // nothing pending right after reset
  `RM2EUL_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "valid result after reset")
  // input side only blocks on a stalled result
  `RM2EUL_ASSERT(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready does not follow output stall")
  // locked results carry zero roll
  `RM2EUL_ASSERT(a_lock_roll, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] == 16'h0000, "roll not zero under lock")
  // pitch stays within a quarter turn
  `RM2EUL_ASSERT(a_pitch_rng, m_axis_tvalid |-> (pitch <= 15'sd12868) && (pitch >= -15'sd12868), "pitch out of range")
endmodule

bind rotation_matrix_to_euler_xyz_unit rm2eul_checker u_rm2eul_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
